### sv/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check on clk, masked while rst is high.
`define AWU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also runs during reset.
`define AWU_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/awu_pkg.sv
package awu_pkg;

  localparam int INDEX_BITS_DEF = 16;
  localparam int ACC_W          = 64;
  localparam int Q_W            = 32;
  localparam int ROOT_W         = 32;
  localparam int DIV_W          = 33;
  localparam int IDX_W          = 16;
  localparam int EPS_W          = 16;
  localparam int CFG_IDX_W      = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS_RATE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EPSILON     = 2'd2;

  localparam logic [Q_W-1:0]   WEIGHT_RATE_RST = 32'd655;
  localparam logic [Q_W-1:0]   BIAS_RATE_RST   = 32'd655;
  localparam logic [EPS_W-1:0] EPSILON_RST     = 16'd1;

  // fields carried alongside the square root
  typedef struct packed {
    logic             sat;
    logic [ACC_W-1:0] prod;
    logic [Q_W-1:0]   weight;
    logic             neg;
    logic [IDX_W-1:0] idx;
  } sqrt_side_t;

  // fields carried alongside the divide
  typedef struct packed {
    logic             sat;
    logic [Q_W-1:0]   weight;
    logic             neg;
    logic [IDX_W-1:0] idx;
  } div_side_t;

endpackage

### sv/adagrad_weight_update_unit.sv
// Adagrad weight update unit, signed Q16.16 parameters.
// Input channel (in_valid / in_stall): one word per element with req_type,
// elem_index, cur_weight, grad_value. Output channel (out_valid / out_stall):
// out_index, new_weight and a saturated flag, one word per input word, in order.
// Config port: cfg_we writes cfg_data into weight_rate, bias_rate or epsilon
// (cfg_index 0..2, others ignored); write only while the unit is idle.
// Throughput: one word per cycle while in_stall is low, back to back, repeated
// indices included (accumulator read-modify-write forwards the previous write).
// Path from accept to out_valid: input stage, accumulator read and update stage,
// then the 32-stage square root, the 32-stage divider and the output register.
// The whole pipeline advances together; when out_valid is held by out_stall,
// in_stall rises and every stage holds, including the accumulator read data.
// Reset: config returns to its defaults and a clearing pass zeroes all
// 2^INDEX_BITS entries (65536 by default) of the accumulator store, one entry
// per cycle; in_stall stays high during it.
module adagrad_weight_update_unit #(
  parameter int INDEX_BITS = awu_pkg::INDEX_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           req_type,
  input  logic [awu_pkg::IDX_W-1:0]      elem_index,
  input  logic signed [awu_pkg::Q_W-1:0] cur_weight,
  input  logic signed [awu_pkg::Q_W-1:0] grad_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [awu_pkg::IDX_W-1:0]      out_index,
  output logic signed [awu_pkg::Q_W-1:0] new_weight,
  output logic                           saturated,
  input  logic                           cfg_we,
  input  logic [awu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [awu_pkg::Q_W-1:0]        cfg_data
);

  `include "assert_macros.svh"

  localparam int ACC_W = awu_pkg::ACC_W;
  localparam int Q_W   = awu_pkg::Q_W;

  // config registers
  logic [Q_W-1:0]            weight_rate;
  logic [Q_W-1:0]            bias_rate;
  logic [awu_pkg::EPS_W-1:0] epsilon;

  always_ff @(posedge clk) begin
    if (rst) begin
      weight_rate <= awu_pkg::WEIGHT_RATE_RST;
      bias_rate   <= awu_pkg::BIAS_RATE_RST;
      epsilon     <= awu_pkg::EPSILON_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        awu_pkg::CFG_WEIGHT_RATE: weight_rate <= cfg_data;
        awu_pkg::CFG_BIAS_RATE:   bias_rate   <= cfg_data;
        awu_pkg::CFG_EPSILON:     epsilon     <= cfg_data[awu_pkg::EPS_W-1:0];
        default: ;
      endcase
    end
  end

  // clearing pass after reset
  logic [INDEX_BITS:0] clr_cnt;
  logic                clearing;
  assign clearing = !clr_cnt[INDEX_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // global advance: the output register is free or being taken
  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = clearing || !en;

  // stage 0: input word, gradient square
  logic                  s0_valid;
  logic                  s0_type;
  logic [awu_pkg::IDX_W-1:0] s0_idx;
  logic [Q_W-1:0]        s0_w;
  logic [Q_W-1:0]        s0_g;
  logic [Q_W-1:0]        s0_mag;
  logic [ACC_W-1:0]      s0_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= in_valid && !clearing;
    end
    if (en) begin
      s0_type <= req_type;
      s0_idx  <= elem_index;
      s0_w    <= cur_weight;
      s0_g    <= grad_value;
    end
  end

  assign s0_mag = s0_g[Q_W-1] ? (~s0_g + 1'b1) : s0_g;
  assign s0_sq  = s0_mag * s0_mag;

  // stage 1: accumulator update, rate product
  logic                      s1_valid;
  logic                      s1_type;
  logic [awu_pkg::IDX_W-1:0] s1_idx;
  logic [INDEX_BITS-1:0]     s1_slot;
  logic [Q_W-1:0]            s1_w;
  logic                      s1_neg;
  logic [Q_W-1:0]            s1_mag;
  logic [ACC_W-1:0]          s1_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= s0_valid;
    end
    if (en) begin
      s1_type <= s0_type;
      s1_idx  <= s0_idx;
      s1_slot <= INDEX_BITS'(s0_idx);
      s1_w    <= s0_w;
      s1_neg  <= s0_g[Q_W-1];
      s1_mag  <= s0_mag;
      s1_sq   <= s0_sq;
    end
  end

  logic [ACC_W-1:0]      ram_rdata;
  logic                  ram_we;
  logic [INDEX_BITS-1:0] ram_waddr;
  logic [ACC_W-1:0]      ram_wdata;

  // last write, covers a read taken at the same edge as that write
  logic                  lw_valid;
  logic [INDEX_BITS-1:0] lw_addr;
  logic [ACC_W-1:0]      lw_data;

  logic [ACC_W-1:0] acc_old;
  logic [ACC_W:0]   acc_sum;
  logic [ACC_W-1:0] acc_new;
  logic             acc_sat;
  logic [Q_W-1:0]   rate;
  logic [ACC_W-1:0] s1_prod;

  always_comb begin
    acc_old = (lw_valid && lw_addr == s1_slot) ? lw_data : ram_rdata;
    acc_sum = {1'b0, acc_old} + {1'b0, s1_sq};
    acc_sat = acc_sum[ACC_W];
    acc_new = acc_sat ? '1 : acc_sum[ACC_W-1:0];
    rate    = s1_type ? bias_rate : weight_rate;
    s1_prod = rate * s1_mag;
  end

  assign ram_we    = clearing || (en && s1_valid);
  assign ram_waddr = clearing ? clr_cnt[INDEX_BITS-1:0] : s1_slot;
  assign ram_wdata = clearing ? '0 : acc_new;

  always_ff @(posedge clk) begin
    if (rst) begin
      lw_valid <= 1'b0;
    end else if (ram_we) begin
      lw_valid <= 1'b1;
    end
    if (ram_we) begin
      lw_addr <= ram_waddr;
      lw_data <= ram_wdata;
    end
  end

  awu_ram #(
    .WIDTH     (ACC_W),
    .ADDR_BITS (INDEX_BITS)
  ) u_acc_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (en),
    .raddr (INDEX_BITS'(s0_idx)),
    .rdata (ram_rdata)
  );

  // square root of the new accumulator
  awu_pkg::sqrt_side_t sq_side_in;
  awu_pkg::sqrt_side_t sq_side_out;
  logic                sq_vld;
  logic [awu_pkg::ROOT_W-1:0] sq_root;

  assign sq_side_in = '{sat: acc_sat, prod: s1_prod, weight: s1_w, neg: s1_neg,
                        idx: s1_idx};

  awu_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (s1_valid),
    .x        (acc_new),
    .side_in  (sq_side_in),
    .out_vld  (sq_vld),
    .root     (sq_root),
    .side_out (sq_side_out)
  );

  // step = rate * |grad| / (root + epsilon)
  logic [awu_pkg::DIV_W-1:0] divisor;
  awu_pkg::div_side_t        dv_side_in;
  awu_pkg::div_side_t        dv_side_out;
  logic                      dv_vld;
  logic [Q_W-1:0]            dv_q;
  logic                      dv_ovf;

  assign divisor    = {1'b0, sq_root} + awu_pkg::DIV_W'(epsilon);
  assign dv_side_in = '{sat: sq_side_out.sat, weight: sq_side_out.weight,
                        neg: sq_side_out.neg, idx: sq_side_out.idx};

  awu_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (sq_vld),
    .prod     (sq_side_out.prod),
    .dvs      (divisor),
    .side_in  (dv_side_in),
    .out_vld  (dv_vld),
    .quot     (dv_q),
    .ovf      (dv_ovf),
    .side_out (dv_side_out)
  );

  // new = cur - signed step, clamped to 32 bits
  logic signed [Q_W+1:0] step;
  logic signed [Q_W+1:0] nw;
  logic                  nw_hi;
  logic                  nw_lo;
  logic [Q_W-1:0]        nw_sat;

  always_comb begin
    step   = dv_side_out.neg ? -$signed({2'b00, dv_q}) : $signed({2'b00, dv_q});
    nw     = $signed({{2{dv_side_out.weight[Q_W-1]}}, dv_side_out.weight}) - step;
    nw_hi  = (nw > $signed({3'b000, {(Q_W-1){1'b1}}}));
    nw_lo  = (nw < $signed({3'b111, {(Q_W-1){1'b0}}}));
    nw_sat = nw_hi ? {1'b0, {(Q_W-1){1'b1}}} :
             nw_lo ? {1'b1, {(Q_W-1){1'b0}}} : nw[Q_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv_vld;
    end
    if (en) begin
      out_index  <= dv_side_out.idx;
      new_weight <= nw_sat;
      saturated  <= dv_side_out.sat || dv_ovf || nw_hi || nw_lo;
    end
  end

  `AWU_ASSERT(a_no_accept_clearing, clearing |-> in_stall, "word accepted during clear")
  `AWU_ASSERT(a_no_item_clearing, clearing |-> !s1_valid, "update during clear pass")
  `AWU_ASSERT(a_acc_monotone, (s1_valid && en) |-> (acc_new >= acc_old), "accumulator fell")

endmodule

### sv/awu_ram.sv
module awu_ram #(
  parameter int WIDTH     = 64,
  parameter int ADDR_BITS = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic                 re,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [0:(1 << ADDR_BITS)-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/awu_sqrt.sv
// Pipelined integer square root, one root bit per stage.
module awu_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_vld,
  input  logic [awu_pkg::ACC_W-1:0]   x,
  input  awu_pkg::sqrt_side_t         side_in,
  output logic                        out_vld,
  output logic [awu_pkg::ROOT_W-1:0]  root,
  output awu_pkg::sqrt_side_t         side_out
);

  localparam int N = awu_pkg::ROOT_W;

  logic                        vld  [0:N];
  logic [35:0]                 rem  [0:N];
  logic [N-1:0]                rt   [0:N];
  logic [awu_pkg::ACC_W-1:0]   xs   [0:N];
  awu_pkg::sqrt_side_t         side [0:N];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_vld;
    end
    if (en) begin
      rem[0]  <= '0;
      rt[0]   <= '0;
      xs[0]   <= x;
      side[0] <= side_in;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [35:0] r2;
    logic [35:0] trial;
    logic        ge;

    always_comb begin
      r2    = {rem[k][33:0], xs[k][awu_pkg::ACC_W-1 -: 2]};
      trial = {2'b00, rt[k], 2'b01};
      ge    = (r2 >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
      if (en) begin
        rem[k+1]  <= ge ? (r2 - trial) : r2;
        rt[k+1]   <= {rt[k][N-2:0], ge};
        xs[k+1]   <= {xs[k][awu_pkg::ACC_W-3:0], 2'b00};
        side[k+1] <= side[k];
      end
    end
  end

  assign out_vld  = vld[N];
  assign root     = rt[N];
  assign side_out = side[N];

endmodule

### sv/awu_div.sv
// Pipelined restoring divide: 64-bit dividend by 33-bit divisor,
// 32 quotient bits, one per stage; quotient overflow saturates, a zero divisor gives zero.
module awu_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_vld,
  input  logic [awu_pkg::ACC_W-1:0]  prod,
  input  logic [awu_pkg::DIV_W-1:0]  dvs,
  input  awu_pkg::div_side_t         side_in,
  output logic                       out_vld,
  output logic [awu_pkg::Q_W-1:0]    quot,
  output logic                       ovf,
  output awu_pkg::div_side_t         side_out
);

  localparam int N = awu_pkg::Q_W;
  localparam int D = awu_pkg::DIV_W;

  logic               vld  [0:N];
  logic [D-1:0]       rem  [0:N];
  logic [N-1:0]       lo   [0:N];
  logic [N-1:0]       q    [0:N];
  logic [D-1:0]       d    [0:N];
  logic               of   [0:N];
  logic               dz   [0:N];
  awu_pkg::div_side_t side [0:N];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_vld;
    end
    if (en) begin
      rem[0]  <= {1'b0, prod[awu_pkg::ACC_W-1 -: N]};
      lo[0]   <= prod[N-1:0];
      q[0]    <= '0;
      d[0]    <= dvs;
      dz[0]   <= (dvs == '0);
      of[0]   <= (dvs != '0) && ({1'b0, prod[awu_pkg::ACC_W-1 -: N]} >= dvs);
      side[0] <= side_in;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [D:0] r2;
    logic       ge;
    logic [D:0] diff;

    always_comb begin
      r2   = {rem[k], lo[k][N-1]};
      ge   = (r2 >= {1'b0, d[k]});
      diff = r2 - {1'b0, d[k]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
      if (en) begin
        rem[k+1]  <= ge ? diff[D-1:0] : r2[D-1:0];
        lo[k+1]   <= {lo[k][N-2:0], 1'b0};
        q[k+1]    <= {q[k][N-2:0], ge};
        d[k+1]    <= d[k];
        dz[k+1]   <= dz[k];
        of[k+1]   <= of[k];
        side[k+1] <= side[k];
      end
    end
  end

  assign out_vld  = vld[N];
  assign quot     = dz[N] ? '0 : (of[N] ? '1 : q[N]);
  assign ovf      = of[N];
  assign side_out = side[N];

endmodule
